/* hw/rtl/wlfc_pkg.sv */
// Package for the word list front coder: transaction types, command codes, constants.
`timescale 1ns / 1ps

package wlfc_pkg;

   // Prefix length cap; the digit is '0' plus at most this value.
   localparam int PREFIX_LEN_CAP_DEF = 9;

   // Result queue depth; room for two results per request plus one in flight.
   localparam int RSP_DEPTH = 4;

   // Command codes carried in the request.
   localparam logic [1:0] CMD_BYTE     = 2'd0;
   localparam logic [1:0] CMD_END_WORD = 2'd1;
   localparam logic [1:0] CMD_END_LIST = 2'd2;
   localparam logic [1:0] CMD_UNUSED   = 2'd3;

   // ASCII zero, base of the prefix digit and the closing byte of a list.
   localparam logic [7:0] ASCII_ZERO = 8'h30;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] in_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       list_end;
   } rsp_type;

endpackage

/* hw/rtl/word_list_front_coder_unit.sv */
// Top level of the word list front coder: prefix tracking and result queue.
`timescale 1ns / 1ps

// Streaming front coder. Each request transaction carries one byte of a word, an
// end of word or an end of list. The first word of a list is passed through as it
// stands; every later word goes out as one ASCII digit (length of the prefix it
// shares with the previous word, capped at PREFIX_LEN_CAP) followed by its
// remaining bytes. End of list sends a '0' flagged with list_end, preceded by the
// pending digit if a later word was left open while still matching, and returns
// the block to its reset state. A request gives zero, one or two response
// transactions; run_last marks the last of them. Rate: one request per cycle
// while each gives at most one response and the response side keeps up; a
// request that gives two responses (digit plus byte, or digit plus list end)
// holds off the next request, set by the single-read port of the four-entry
// response queue, which accepts a request only while it holds at most one
// entry. Responses are registered in the queue. No clearing pass after reset.
module word_list_front_coder_unit #(
   parameter int PREFIX_LEN_CAP = wlfc_pkg::PREFIX_LEN_CAP_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  wlfc_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output wlfc_pkg::rsp_type rsp_payload
);
   import wlfc_pkg::*;

   // Length counters must hold the cap itself; the head index only below it.
   localparam int LEN_W = $clog2(PREFIX_LEN_CAP + 1);
   localparam int IDX_W = (PREFIX_LEN_CAP > 1) ? $clog2(PREFIX_LEN_CAP) : 1;
   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   localparam logic [LEN_W-1:0] CAP_LEN   = LEN_W'(PREFIX_LEN_CAP);
   localparam logic [LEN_W-1:0] CAP_LAST  = LEN_W'(PREFIX_LEN_CAP - 1);
   localparam logic [7:0]       CAP_DIGIT = ASCII_ZERO + 8'(PREFIX_LEN_CAP);

   // ---------------------------------------------------------------------------
   // Word state
   // ---------------------------------------------------------------------------
   logic [7:0]       prev_head_ff [PREFIX_LEN_CAP];  // head of the previous word
   logic [LEN_W-1:0] prev_len_ff, prev_len_in;        // kept length of previous word
   logic [LEN_W-1:0] cur_pos_ff, cur_pos_in;          // bytes seen, held at the cap
   logic             in_prefix_ff, in_prefix_in;      // still matching previous word
   logic             first_word_ff, first_word_in;    // first word of the list

   // ---------------------------------------------------------------------------
   // Response queue
   // ---------------------------------------------------------------------------
   rsp_type          rsp_q_ff [RSP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic             req_take;
   logic             rsp_take;
   logic [1:0]       push_n;
   rsp_type          res0, res1;
   logic             head_wr;
   logic [7:0]       cur_digit;
   logic             keep_room;
   logic             head_match;

   // Accept only while two free entries are guaranteed.
   assign req_stall = (count_ff > CNT_W'(1));
   assign req_take  = req_valid && !req_stall;

   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = rsp_q_ff[rd_ptr_ff];
   assign rsp_take    = rsp_valid && !rsp_stall;

   assign cur_digit  = ASCII_ZERO + 8'(cur_pos_ff);
   assign keep_room  = (cur_pos_ff < CAP_LEN);
   // Read of the head only counts where it was written (below prev_len).
   assign head_match = (cur_pos_ff < prev_len_ff) && keep_room &&
                       (prev_head_ff[cur_pos_ff[IDX_W-1:0]] == req_payload.in_byte);

   // ---------------------------------------------------------------------------
   // Encoder: results and next word state for the request on the port
   // ---------------------------------------------------------------------------
   always_comb begin
      prev_len_in   = prev_len_ff;
      cur_pos_in    = cur_pos_ff;
      in_prefix_in  = in_prefix_ff;
      first_word_in = first_word_ff;
      head_wr       = 1'b0;
      push_n        = 2'd0;
      res0          = '{out_byte: req_payload.in_byte, run_last: 1'b1, list_end: 1'b0};
      res1          = '{out_byte: req_payload.in_byte, run_last: 1'b1, list_end: 1'b0};

      unique case (req_payload.cmd)
         CMD_BYTE: begin
            // Every byte is kept while there is room in the head.
            head_wr = keep_room;
            if (keep_room) begin
               cur_pos_in = cur_pos_ff + LEN_W'(1);
            end
            if (first_word_ff || !in_prefix_ff) begin
               push_n = 2'd1;
            end else if (head_match) begin
               // Matching byte that reaches the cap sends the cap digit alone.
               if (cur_pos_ff == CAP_LAST) begin
                  res0.out_byte = CAP_DIGIT;
                  push_n        = 2'd1;
                  in_prefix_in  = 1'b0;
               end
            end else begin
               // Mismatch: digit then the byte itself.
               res0.out_byte = cur_digit;
               res0.run_last = 1'b0;
               push_n        = 2'd2;
               in_prefix_in  = 1'b0;
            end
         end
         CMD_END_WORD: begin
            if (!first_word_ff && in_prefix_ff) begin
               res0.out_byte = cur_digit;
               push_n        = 2'd1;
            end
            prev_len_in   = cur_pos_ff;
            cur_pos_in    = '0;
            in_prefix_in  = 1'b1;
            first_word_in = 1'b0;
         end
         CMD_END_LIST: begin
            res1 = '{out_byte: ASCII_ZERO, run_last: 1'b1, list_end: 1'b1};
            if (!first_word_ff && in_prefix_ff && (cur_pos_ff != '0)) begin
               // Open word still matching: its digit goes before the list end.
               res0.out_byte = cur_digit;
               res0.run_last = 1'b0;
               push_n        = 2'd2;
            end else begin
               res0   = res1;
               push_n = 2'd1;
            end
            prev_len_in   = '0;
            cur_pos_in    = '0;
            in_prefix_in  = 1'b1;
            first_word_in = 1'b1;
         end
         CMD_UNUSED: begin
            // Ignored.
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------------------
   // Queue pointers
   // ---------------------------------------------------------------------------
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (req_take) begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
         count_in  = count_ff + CNT_W'(push_n);
      end
      if (rsp_take) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(1);
         count_in  = count_in - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_len_ff   <= '0;
         cur_pos_ff    <= '0;
         in_prefix_ff  <= 1'b1;
         first_word_ff <= 1'b1;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         if (req_take) begin
            prev_len_ff   <= prev_len_in;
            cur_pos_ff    <= cur_pos_in;
            in_prefix_ff  <= in_prefix_in;
            first_word_ff <= first_word_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload storage, no reset.
   always_ff @(posedge clock) begin
      if (req_take && head_wr) begin
         prev_head_ff[cur_pos_ff[IDX_W-1:0]] <= req_payload.in_byte;
      end
      if (req_take && (push_n != 2'd0)) begin
         rsp_q_ff[wr_ptr_ff] <= res0;
      end
      if (req_take && (push_n == 2'd2)) begin
         rsp_q_ff[wr_ptr_ff + PTR_W'(1)] <= res1;
      end
   end

endmodule
